[src/xts_aes128_sector_decrypt_defines.svh]
// Assertion macros shared by the XTS-AES-128 sector decrypt block.
// Depends on nothing; included by the modules that assert.
`ifndef XTS_AES128_SECTOR_DECRYPT_DEFINES_SVH
`define XTS_AES128_SECTOR_DECRYPT_DEFINES_SVH
// check that an antecedent implies a consequent in the same cycle
`define XTS_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// check that an antecedent implies a consequent in the next cycle
`define XTS_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[src/xts_pkg.sv]
// Package for the XTS-AES-128 sector decrypt block: types, constants, AES functions.
// Depends on nothing.
`timescale 1ns / 1ps
package xts_pkg;
    localparam logic [1:0] REG_DKEY_LO = 2'd0;
    localparam logic [1:0] REG_DKEY_HI = 2'd1;
    localparam logic [1:0] REG_TKEY_LO = 2'd2;
    localparam logic [1:0] REG_TKEY_HI = 2'd3;
    localparam logic [7:0] GF_POLY = 8'h87;

    // queued word from front to back
    typedef struct packed {
        logic         new_tweak;
        logic         done;
        logic [63:0]  sector;
        logic [127:0] cipher;
    } xts_job_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_TWK, ST_RKEY, ST_DEC, ST_OUT
    } xts_state_t;

    localparam logic [7:0] SBOX [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (SBOX[i] == v) r = i[7:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // bytes are held with byte 0 in bits 7:0
    function automatic logic [7:0] gb(input logic [127:0] s, input int i);
        return s[8*i +: 8];
    endfunction

    // next round key from previous one, rcon given
    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t;
        logic [127:0] n;
        t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
             SBOX[k[111:104]] ^ rc};
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

    // previous round key from next one
    function automatic logic [127:0] key_bwd(input logic [127:0] n, input logic [7:0] rc);
        logic [31:0] t;
        logic [127:0] k;
        k[127:96] = n[127:96] ^ n[95:64];
        k[95:64]  = n[95:64] ^ n[63:32];
        k[63:32]  = n[63:32] ^ n[31:0];
        t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
             SBOX[k[111:104]] ^ rc};
        k[31:0] = n[31:0] ^ t;
        return k;
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [127:0] t, m;
        logic [7:0] a0, a1, a2, a3;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[8*(r+4*c) +: 8] = SBOX[gb(s, r + 4*((c + r) & 3))];
        for (int c = 0; c < 4; c++) begin
            a0 = t[8*(4*c) +: 8]; a1 = t[8*(4*c+1) +: 8];
            a2 = t[8*(4*c+2) +: 8]; a3 = t[8*(4*c+3) +: 8];
            m[8*(4*c) +: 8]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            m[8*(4*c+1) +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            m[8*(4*c+2) +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            m[8*(4*c+3) +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return (last ? t : m) ^ rk;
    endfunction

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] r, x;
        r = 8'h00; x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) r = r ^ x;
            x = xt(x);
        end
        return r;
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [127:0] t, m;
        logic [7:0] a0, a1, a2, a3;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[8*(r+4*c) +: 8] = inv_sbox(gb(s, r + 4*((c - r + 4) & 3)));
        t = t ^ rk;
        for (int c = 0; c < 4; c++) begin
            a0 = t[8*(4*c) +: 8]; a1 = t[8*(4*c+1) +: 8];
            a2 = t[8*(4*c+2) +: 8]; a3 = t[8*(4*c+3) +: 8];
            m[8*(4*c) +: 8]   = gm(a0,4'd14) ^ gm(a1,4'd11) ^ gm(a2,4'd13) ^ gm(a3,4'd9);
            m[8*(4*c+1) +: 8] = gm(a0,4'd9) ^ gm(a1,4'd14) ^ gm(a2,4'd11) ^ gm(a3,4'd13);
            m[8*(4*c+2) +: 8] = gm(a0,4'd13) ^ gm(a1,4'd9) ^ gm(a2,4'd14) ^ gm(a3,4'd11);
            m[8*(4*c+3) +: 8] = gm(a0,4'd11) ^ gm(a1,4'd13) ^ gm(a2,4'd9) ^ gm(a3,4'd14);
        end
        return last ? t : m;
    endfunction
endpackage

[src/xts_front.sv]
// Front end: accepts ciphertext words, tracks sector and block count, queues jobs.
// Depends on xts_pkg.
`timescale 1ns / 1ps
module xts_front import xts_pkg::*; #(
    parameter int BLOCKS_PER_SECTOR = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         start_run,
    input  logic [63:0]  start_sector,
    input  logic [127:0] cipher,
    output logic         job_valid,
    input  logic         job_ready,
    output xts_job_t     job
);
    localparam int CW = $clog2(BLOCKS_PER_SECTOR + 1);
    localparam logic [CW-1:0] LAST = CW'(BLOCKS_PER_SECTOR - 1);

    logic [63:0]   sector_reg;
    logic [CW-1:0] blk_reg;
    xts_job_t      q_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;
    xts_job_t      nj;
    logic [63:0]   sec_now;
    logic [CW-1:0] blk_now;

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rp_reg];

    // classify the incoming word
    always_comb begin
        sec_now = start_run ? start_sector : sector_reg;
        blk_now = start_run ? '0 : blk_reg;
        nj.new_tweak = (blk_now == '0);
        nj.done      = (blk_now == LAST);
        nj.sector    = sec_now;
        nj.cipher    = cipher;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_reg <= '0;
            blk_reg    <= '0;
            wp_reg     <= 1'b0;
            rp_reg     <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                q_reg[wp_reg] <= nj;
                wp_reg <= !wp_reg;
                if (blk_now == LAST) begin
                    blk_reg    <= '0;
                    sector_reg <= sec_now + 64'd1;
                end else begin
                    blk_reg    <= blk_now + CW'(1);
                    sector_reg <= sec_now;
                end
            end
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[src/xts_back.sv]
// Back end: tweak generation and block decryption, sharing one state and key register.
// Depends on xts_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "xts_aes128_sector_decrypt_defines.svh"
module xts_back import xts_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [127:0] dec_key,
    input  logic [127:0] twk_key,
    input  logic         job_valid,
    output logic         job_ready,
    input  xts_job_t     job,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [127:0] plain,
    output logic         sector_done
);
    xts_state_t   st_reg, st_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [127:0] s_reg, s_next, k_reg, k_next, tw_reg, tw_next, p_reg, p_next;
    logic [127:0] cph_reg, cph_next;
    logic         done_reg, done_next, ov_reg, ov_next;
    logic [127:0] rnd_out;
    logic         tw_carry;

    assign job_ready   = (st_reg == ST_IDLE) && !ov_reg;
    assign out_valid   = ov_reg;
    assign plain       = p_reg;
    assign sector_done = done_reg;
    assign tw_carry    = tw_reg[127];

    always_comb begin
        st_next = st_reg; rnd_next = rnd_reg; s_next = s_reg; k_next = k_reg;
        tw_next = tw_reg; p_next = p_reg; done_next = done_reg; ov_next = ov_reg;
        cph_next = cph_reg;
        rnd_out = '0;
        if (ov_reg && out_ready) ov_next = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                if (job_valid && !ov_reg) begin
                    cph_next  = job.cipher;
                    done_next = job.done;
                    rnd_next  = 4'd0;
                    if (job.new_tweak) begin
                        s_next  = {64'd0, job.sector} ^ twk_key;
                        k_next  = twk_key;
                        st_next = ST_TWK;
                    end else begin
                        k_next  = dec_key;
                        st_next = ST_RKEY;
                    end
                end
            end
            // ten encryption rounds of the sector number
            ST_TWK: begin
                k_next  = key_fwd(k_reg, RCON[rnd_reg]);
                rnd_out = enc_round(s_reg, k_next, rnd_reg == 4'd9);
                s_next  = rnd_out;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'd9) begin
                    tw_next  = rnd_out;
                    k_next   = dec_key;
                    rnd_next = 4'd0;
                    st_next  = ST_RKEY;
                end
            end
            // walk the data key forward to the last round key
            ST_RKEY: begin
                k_next   = key_fwd(k_reg, RCON[rnd_reg]);
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'd9) begin
                    s_next   = cph_reg ^ tw_reg ^ k_next;
                    rnd_next = 4'd9;
                    st_next  = ST_DEC;
                end
            end
            // inverse rounds, stepping the key backward
            ST_DEC: begin
                k_next  = key_bwd(k_reg, RCON[rnd_reg]);
                rnd_out = dec_round(s_reg, k_next, rnd_reg == 4'd0);
                s_next  = rnd_out;
                rnd_next = rnd_reg - 4'd1;
                if (rnd_reg == 4'd0) st_next = ST_OUT;
            end
            ST_OUT: begin
                p_next  = s_reg ^ tw_reg;
                tw_next = {tw_reg[126:0], 1'b0} ^ {120'd0, tw_carry ? GF_POLY : 8'h00};
                ov_next = 1'b1;
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            tw_reg <= '0;
        end else begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            tw_reg <= tw_next;
        end
        rnd_reg <= rnd_next; s_reg <= s_next; k_reg <= k_next; p_reg <= p_next;
        done_reg <= done_next; cph_reg <= cph_next;
    end

    `XTS_ASSERT_IMP(a_no_take_busy, aclk, aresetn, job_ready, (st_reg == ST_IDLE) && !ov_reg)
    `XTS_ASSERT_NEXT(a_out_sets, aclk, aresetn, st_reg == ST_OUT, ov_reg)
    `XTS_ASSERT_NEXT(a_out_holds, aclk, aresetn, ov_reg && !out_ready, ov_reg && $stable(p_reg))
endmodule

[src/xts_aes128_sector_decrypt.sv]
// XTS-AES-128 sector decrypt. At the first block of a sector a word passes the queue hop,
// 10 tweak rounds, 10 key steps, 10 inverse rounds and the output register; other blocks
// skip the tweak rounds, though the data round key is still walked forward each block.
// One block at a time through the shared state and key registers: a new block is not taken
// until the previous result has been accepted; a two-entry job queue decouples the input side.
// Synchronous active-low reset clears keys, sector, block count and tweak to zero.
`timescale 1ns / 1ps
module xts_aes128_sector_decrypt import xts_pkg::*; #(
    parameter int BLOCKS_PER_SECTOR = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // start_sector, cipher_low, cipher_high
    input  logic         s_tuser,   // start_run
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // plain_low, plain_high
    output logic         m_tlast    // sector_done
);
    logic [63:0] dk_lo_reg, dk_hi_reg, tk_lo_reg, tk_hi_reg;
    logic        job_valid, job_ready;
    xts_job_t    job;

    assign cfg_ready = 1'b1;

    // hold key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dk_lo_reg <= '0; dk_hi_reg <= '0; tk_lo_reg <= '0; tk_hi_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DKEY_LO: dk_lo_reg <= cfg_data;
                REG_DKEY_HI: dk_hi_reg <= cfg_data;
                REG_TKEY_LO: tk_lo_reg <= cfg_data;
                REG_TKEY_HI: tk_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    xts_front #(.BLOCKS_PER_SECTOR(BLOCKS_PER_SECTOR)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .start_run(s_tuser), .start_sector(s_tdata[63:0]), .cipher(s_tdata[191:64]),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    xts_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .dec_key({dk_hi_reg, dk_lo_reg}), .twk_key({tk_hi_reg, tk_lo_reg}),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .plain(m_tdata), .sector_done(m_tlast)
    );
endmodule

[dv/tb.sv]
// Testbench for the XTS-AES-128 sector decrypt block: directed and random blocks
// checked against an in-bench AES/XTS predictor. Depends on xts_pkg and the RTL top.
`timescale 1ns / 1ps
module tb;
    import xts_pkg::*;

    typedef struct {
        logic [127:0] plain;
        logic         last;
    } plain_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = REG_DKEY_LO;
    logic [63:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;    // start_sector, cipher_low, cipher_high
    logic         s_tuser = 1'b0;  // start_run
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;         // plain_low, plain_high
    logic         m_tlast;         // sector_done

    // predictor state
    logic [7:0]   fwd_box [256];
    logic [7:0]   rev_box [256];
    logic [127:0] dec_key = '0;
    logic [127:0] twk_key = '0;
    logic [127:0] tweak = '0;
    logic [63:0]  sector = '0;
    int           blk_idx = 0;
    plain_word_t  plain_q [$];
    int           fails = 0;
    bit           idle_en = 1'b1;
    int           cycles = 0;
    int           stall_left = 0;

    xts_aes128_sector_decrypt dut (.*);

    always #5 aclk = ~aclk;

    // ---------------- AES arithmetic ----------------
    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = dbl(a);
        end
        return r;
    endfunction

    // build the S-box from the field inverse and the affine map
    task automatic build_boxes();
        logic [7:0] v, x;
        for (int a = 0; a < 256; a++) begin
            v = 8'h00;
            for (int b = 1; b < 256; b++)
                if (a != 0 && fmul(a[7:0], b[7:0]) == 8'h01) v = b[7:0];
            x = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                ^ {v[3:0], v[7:4]} ^ 8'h63;
            fwd_box[a] = x;
            rev_box[x] = a[7:0];
        end
    endtask

    function automatic void expand(input logic [127:0] key, output logic [127:0] rk [11]);
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = key[32*i +: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if ((i & 3) == 0) begin
                t = {fwd_box[t[7:0]], fwd_box[t[31:24]], fwd_box[t[23:16]],
                     fwd_box[t[15:8]] ^ rc};
                rc = dbl(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) rk[r] = {w[4*r+3], w[4*r+2], w[4*r+1], w[4*r]};
    endfunction

    function automatic logic [127:0] encrypt(input logic [127:0] key, input logic [127:0] s);
        logic [127:0] rk [11];
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        expand(key, rk);
        s ^= rk[0];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    t[8*(r+4*c) +: 8] = fwd_box[s[8*(r+4*((c+r)&3)) +: 8]];
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[32*c +: 8]; a1 = t[32*c+8 +: 8];
                    a2 = t[32*c+16 +: 8]; a3 = t[32*c+24 +: 8];
                    s[32*c +: 8]    = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                    s[32*c+8 +: 8]  = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                    s[32*c+16 +: 8] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                    s[32*c+24 +: 8] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                end
            end else begin
                s = t;
            end
            s ^= rk[rnd];
        end
        return s;
    endfunction

    function automatic logic [127:0] decrypt(input logic [127:0] key, input logic [127:0] s);
        logic [127:0] rk [11];
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        expand(key, rk);
        s ^= rk[10];
        for (int rnd = 9; rnd >= 0; rnd--) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    t[8*(r+4*c) +: 8] = rev_box[s[8*(r+4*((c-r+4)&3)) +: 8]];
            t ^= rk[rnd];
            if (rnd > 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[32*c +: 8]; a1 = t[32*c+8 +: 8];
                    a2 = t[32*c+16 +: 8]; a3 = t[32*c+24 +: 8];
                    s[32*c +: 8]    = fmul(a0, 8'd14) ^ fmul(a1, 8'd11)
                                      ^ fmul(a2, 8'd13) ^ fmul(a3, 8'd9);
                    s[32*c+8 +: 8]  = fmul(a0, 8'd9) ^ fmul(a1, 8'd14)
                                      ^ fmul(a2, 8'd11) ^ fmul(a3, 8'd13);
                    s[32*c+16 +: 8] = fmul(a0, 8'd13) ^ fmul(a1, 8'd9)
                                      ^ fmul(a2, 8'd14) ^ fmul(a3, 8'd11);
                    s[32*c+24 +: 8] = fmul(a0, 8'd11) ^ fmul(a1, 8'd13)
                                      ^ fmul(a2, 8'd9) ^ fmul(a3, 8'd14);
                end
            end else begin
                s = t;
            end
        end
        return s;
    endfunction

    // advance the sector state by one block and queue the plaintext it yields
    function automatic void predict_plain(input logic run, input logic [63:0] first,
                                          input logic [127:0] cipher);
        plain_word_t w;
        logic        carry;
        if (run) begin
            sector = first;
            blk_idx = 0;
        end
        if (blk_idx == 0) tweak = encrypt(twk_key, {64'h0, sector});
        w.plain = decrypt(dec_key, cipher ^ tweak) ^ tweak;
        carry = tweak[127];
        tweak = tweak << 1;
        if (carry) tweak[7:0] ^= GF_POLY;
        blk_idx++;
        w.last = 1'b0;
        if (blk_idx >= 256) begin
            blk_idx = 0;
            sector++;
            w.last = 1'b1;
        end
        plain_q.push_back(w);
    endfunction

    // ---------------- drivers ----------------
    task automatic send_block(input logic run, input logic [63:0] first,
                              input logic [127:0] cipher);
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {cipher, first};
        s_tuser = run;
        do @(posedge aclk); while (!s_tready);
        predict_plain(run, first, cipher);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (plain_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DKEY_LO: dec_key[63:0] = val;
            REG_DKEY_HI: dec_key[127:64] = val;
            REG_TKEY_LO: twk_key[63:0] = val;
            default:     twk_key[127:64] = val;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_keys(input logic [127:0] dk, input logic [127:0] tk);
        drain();
        write_reg(REG_DKEY_LO, dk[63:0]);
        write_reg(REG_DKEY_HI, dk[127:64]);
        write_reg(REG_TKEY_LO, tk[63:0]);
        write_reg(REG_TKEY_HI, tk[127:64]);
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // ---------------- tests ----------------
    // blocks after reset with no run start belong to sector 0, zero keys
    task automatic test_no_start();
        send_block(1'b0, 64'h0, '0);
        send_block(1'b0, {64{1'b1}}, '1);
        send_block(1'b0, {$urandom, $urandom}, rand128());
    endtask

    // field extremes, a restart mid-sector, and the top sector number
    task automatic test_extremes();
        load_keys('1, '1);
        send_block(1'b1, 64'h0, '1);
        send_block(1'b0, 64'h0, '0);
        send_block(1'b1, {64{1'b1}}, '0);
        send_block(1'b0, 64'h0, '1);
        send_block(1'b1, 64'h1, {64'h0, {64{1'b1}}});
        send_block(1'b1, 64'h8000_0000_0000_0000, {{64{1'b1}}, 64'h0});
        send_block(1'b0, 64'h0, rand128());
    endtask

    // a key change inside a sector keeps the tweak but uses the new data key
    task automatic test_key_change();
        load_keys(rand128(), rand128());
        send_block(1'b1, {$urandom, $urandom}, rand128());
        send_block(1'b0, 64'h0, rand128());
        load_keys(rand128(), rand128());
        send_block(1'b0, 64'h0, rand128());
        send_block(1'b0, 64'h0, rand128());
    endtask

    // random runs, mostly short, some spanning whole sectors and the wrap
    task automatic test_random();
        int sent;
        int len;
        logic [63:0] first;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: load_keys('0, '1);
                1: load_keys('1, '0);
                default: load_keys(rand128(), rand128());
            endcase
            if (ph == 3) idle_en = 1'b0;
            sent = 0;
            while (sent < 250) begin
                len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(256, 300))
                                                  : int'($urandom_range(1, 30));
                case ($urandom_range(0, 3))
                    0: first = {64{1'b1}} - 64'($urandom_range(0, 1));
                    1: first = 64'($urandom_range(0, 3));
                    default: first = {$urandom, $urandom};
                endcase
                send_block(1'b1, first, rand128());
                for (int i = 1; i < len; i++)
                    send_block(1'b0, {$urandom, $urandom}, rand128());
                sent += len;
            end
        end
    endtask

    // ---------------- result side ----------------
    // hold off the result channel in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_en && aresetn && $urandom_range(0, 7) == 0) begin
            stall_left <= int'($urandom_range(0, 8));
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each accepted word with the oldest predicted plaintext
    always @(posedge aclk) begin
        plain_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (plain_q.size() == 0) begin
                $error("unexpected word: plain=%h last=%b", m_tdata, m_tlast);
                fails++;
            end else begin
                w = plain_q.pop_front();
                if (m_tdata[63:0] !== w.plain[63:0]) begin
                    $error("plain_low: expected %h got %h", w.plain[63:0], m_tdata[63:0]);
                    fails++;
                end
                if (m_tdata[127:64] !== w.plain[127:64]) begin
                    $error("plain_high: expected %h got %h", w.plain[127:64],
                           m_tdata[127:64]);
                    fails++;
                end
                if (m_tlast !== w.last) begin
                    $error("sector_done: expected %b got %b", w.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    // end the run if it stalls
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        build_boxes();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_no_start();
        test_extremes();
        test_key_change();
        test_random();
        drain();
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+src
src/xts_pkg.sv
src/xts_front.sv
src/xts_back.sv
src/xts_aes128_sector_decrypt.sv
dv/tb.sv
